[rtl/rc6d_pkg.sv]
// Shared types and constants for the RC6 infrared frame decoder.
// No dependencies.
package rc6d_pkg;

  typedef struct packed {
    logic [1:0]  sample_kind;
    logic [23:0] duration;
    logic        end_of_capture;
  } rc6d_in_t;

  typedef struct packed {
    logic        found;
    logic [23:0] head_bits;
    logic        toggle;
    logic [12:0] command_code;
    logic [1:0]  cell_offset;
    logic        mark_is_one;
  } rc6d_out_t;

  localparam logic [1:0] KIND_SPACE = 2'd0;
  localparam logic [1:0] KIND_PULSE = 2'd1;

  localparam logic [2:0] REG_UNIT       = 3'd0;
  localparam logic [2:0] REG_IDLE       = 3'd1;
  localparam logic [2:0] REG_MARK_MIN   = 3'd2;
  localparam logic [2:0] REG_MARK_MAX   = 3'd3;
  localparam logic [2:0] REG_SPACE_MIN  = 3'd4;
  localparam logic [2:0] REG_SPACE_MAX  = 3'd5;
  localparam logic [2:0] REG_EXP_PRE    = 3'd6;
  localparam logic [2:0] REG_TOGGLE     = 3'd7;

  localparam int unsigned TRAILER_POS = 4;
  localparam int unsigned MIN_SAMPLES = 10;
  localparam logic [3:0]  COUNT_SAT   = 4'd15;

endpackage

[rtl/rc6_ir_frame_decoder.sv]
// RC6 mode 6A infrared frame decoder, top level.
// Depends on rc6d_pkg, rc6d_div and rc6d_ram.
//
// Usage: drive one mark/space sample on in_data with start high; it is taken
// at an edge where start is high and busy is low. A leader sample, or a sample
// that is not converted, holds busy only through the end state once taken. A
// later sample runs the divider to round its duration to cells, then writes
// one cell per cycle into the cell memory, keeping busy high until the end
// state is done. The item with end_of_capture then runs up to eight decode
// attempts; each bit takes an address step, one read step per cell and a
// check step, and out_valid then pulses for one cycle with the result. Only
// the closing item gives a result. Configuration writes on cfg_valid/cfg_ready
// are taken at any time; cfg_ready is always high. Reset returns registers to
// defaults and clears capture state; cell memory is not cleared since only
// written cells are read. The receiver cannot stall: out_valid lasts one cycle.
module rc6_ir_frame_decoder
  import rc6d_pkg::*;
#(
  parameter int MAX_CELLS  = 128,
  parameter int FRAME_BITS = 37,
  parameter int CODE_BITS  = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rc6d_in_t    in_data,
  output logic        out_valid,
  output rc6d_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int PW = CW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_END   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [11:0] unit_r;
  logic [23:0] idle_r, mmin_r, mmax_r, smin_r, smax_r, exp_r, tmask_r;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] ccount_r, ccount_nxt;
  logic [3:0]    scount_r, scount_nxt;
  logic          lok_r, lok_nxt;
  logic          stop_r, stop_nxt;
  logic          last_r, last_nxt;
  logic          lvl_r, lvl_nxt;
  logic [CW-1:0] nleft_r, nleft_nxt;

  logic [1:0]        off_r, off_nxt;
  logic              pol_r, pol_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [3:0]        cbuf_r, cbuf_nxt;
  logic [5:0]        bit_r, bit_nxt;
  logic [FRAME_BITS-1:0] acc_r, acc_nxt;
  rc6d_out_t         res_r, res_nxt;

  logic          div_go, div_done;
  logic [24:0]   div_q;
  logic [11:0]   u_eff;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic          rd_data;

  logic [CW-1:0] room;
  logic [24:0]   nq;
  logic          trailer;
  logic [2:0]    need;
  logic          first;
  logic          cells_ok;
  logic [FRAME_BITS-1:0] frame;
  logic [FRAME_BITS-CODE_BITS-1:0] pre;
  logic [23:0]   pre24;

  assign cfg_ready = 1'b1;
  assign busy = (st_r != S_IDLE);
  assign u_eff = (unit_r == 12'd0) ? 12'd1 : unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= 12'd444;
      idle_r <= 24'd20000;
      mmin_r <= 24'd2200;
      mmax_r <= 24'd3200;
      smin_r <= 24'd650;
      smax_r <= 24'd1200;
      exp_r <= 24'h1bff80;
      tmask_r <= 24'h000004;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_UNIT:      unit_r <= cfg_data[11:0];
        REG_IDLE:      idle_r <= cfg_data;
        REG_MARK_MIN:  mmin_r <= cfg_data;
        REG_MARK_MAX:  mmax_r <= cfg_data;
        REG_SPACE_MIN: smin_r <= cfg_data;
        REG_SPACE_MAX: smax_r <= cfg_data;
        REG_EXP_PRE:   exp_r <= cfg_data;
        REG_TOGGLE:    tmask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rc6d_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .dividend({1'b0, in_data.duration} + {14'd0, u_eff[11:1]}),
    .divisor(u_eff), .done(div_done), .quotient(div_q)
  );

  rc6d_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_cells (
    .clk(clk), .wr_en(wr_en), .wr_addr(ccount_r[AW-1:0]), .wr_data(lvl_r),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign room = CW'(MAX_CELLS) - ccount_r;
  assign trailer = (bit_r == 6'(TRAILER_POS));
  assign need = trailer ? 3'd4 : 3'd2;
  // The address runs one cell ahead of the capture to cover the read latency.
  assign rd_addr = AW'(p_r + PW'(k_nxt));
  assign first = cbuf_r[0];
  assign cells_ok = trailer ?
      (cbuf_r[0] == cbuf_r[1] && cbuf_r[2] == cbuf_r[3] && cbuf_r[0] != cbuf_r[2]) :
      (cbuf_r[0] != cbuf_r[1]);
  assign frame = {acc_r[FRAME_BITS-2:0], pol_r ? first : !first};
  assign pre = frame[FRAME_BITS-1:CODE_BITS];
  assign pre24 = 24'(pre);

  always_comb begin
    st_nxt = st_r;
    ccount_nxt = ccount_r;
    scount_nxt = scount_r;
    lok_nxt = lok_r;
    stop_nxt = stop_r;
    last_nxt = last_r;
    lvl_nxt = lvl_r;
    nleft_nxt = nleft_r;
    off_nxt = off_r;
    pol_nxt = pol_r;
    p_nxt = p_r;
    k_nxt = k_r;
    cbuf_nxt = cbuf_r;
    bit_nxt = bit_r;
    acc_nxt = acc_r;
    res_nxt = res_r;
    div_go = 1'b0;
    wr_en = 1'b0;
    nq = '0;
    out_valid = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          last_nxt = in_data.end_of_capture;
          lvl_nxt = (in_data.sample_kind == KIND_PULSE);
          if (scount_r != COUNT_SAT) scount_nxt = scount_r + 4'd1;
          st_nxt = S_END;
          if (scount_r == 4'd0) begin
            lok_nxt = in_data.sample_kind == KIND_PULSE &&
                      in_data.duration >= mmin_r && in_data.duration <= mmax_r;
          end else if (scount_r == 4'd1) begin
            lok_nxt = lok_r && in_data.sample_kind == KIND_SPACE &&
                      in_data.duration >= smin_r && in_data.duration <= smax_r;
          end else if (!stop_r && ccount_r < CW'(MAX_CELLS)) begin
            if (in_data.duration > idle_r) begin
              stop_nxt = 1'b1;
            end else begin
              div_go = 1'b1;
              st_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          nq = (div_q == 25'd0) ? 25'd1 : div_q;
          nleft_nxt = (nq > 25'(room)) ? room : CW'(nq);
          st_nxt = S_FILL;
        end
      end
      S_FILL: begin
        wr_en = 1'b1;
        ccount_nxt = ccount_r + CW'(1);
        nleft_nxt = nleft_r - CW'(1);
        if (nleft_r == CW'(1)) st_nxt = S_END;
      end
      S_END: begin
        if (!last_r) begin
          st_nxt = S_IDLE;
        end else begin
          res_nxt = '0;
          off_nxt = 2'd0;
          pol_nxt = 1'b0;
          p_nxt = '0;
          bit_nxt = '0;
          k_nxt = '0;
          acc_nxt = '0;
          if (scount_r >= 4'(MIN_SAMPLES) && lok_r) st_nxt = S_RD;
          else st_nxt = S_OUT;
        end
      end
      S_RD: begin
        // Cells are fetched one at a time; the bound is checked before any is used.
        if (p_r + PW'(need) > PW'(ccount_r)) begin
          st_nxt = S_NEXT;
        end else begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        cbuf_nxt[k_r[1:0]] = rd_data;
        if (k_r == need - 3'd1) begin
          st_nxt = S_CHK;
        end else begin
          k_nxt = k_r + 3'd1;
          st_nxt = S_WAIT;
        end
      end
      S_CHK: begin
        k_nxt = '0;
        if (!cells_ok) begin
          st_nxt = S_NEXT;
        end else if (bit_r == 6'(FRAME_BITS - 1)) begin
          if ((pre24 & ~tmask_r) == exp_r &&
              (pre >> 24) == '0) begin
            res_nxt.found = 1'b1;
            res_nxt.head_bits = pre24;
            res_nxt.toggle = |(pre24 & tmask_r);
            res_nxt.command_code = 13'(frame[CODE_BITS-1:0]);
            res_nxt.cell_offset = off_r;
            res_nxt.mark_is_one = pol_r;
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_NEXT;
          end
        end else begin
          acc_nxt = frame;
          bit_nxt = bit_r + 6'd1;
          p_nxt = p_r + PW'(need);
          st_nxt = S_RD;
        end
      end
      S_NEXT: begin
        p_nxt = PW'(off_r);
        bit_nxt = '0;
        acc_nxt = '0;
        k_nxt = '0;
        if (!pol_r) begin
          pol_nxt = 1'b1;
          st_nxt = S_RD;
        end else if (off_r == 2'd3) begin
          st_nxt = S_OUT;
        end else begin
          pol_nxt = 1'b0;
          off_nxt = off_r + 2'd1;
          p_nxt = PW'(off_r + 2'd1);
          st_nxt = S_RD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        ccount_nxt = '0;
        scount_nxt = '0;
        lok_nxt = 1'b0;
        stop_nxt = 1'b0;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ccount_r <= '0;
      scount_r <= '0;
      lok_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ccount_r <= ccount_nxt;
      scount_r <= scount_nxt;
      lok_r <= lok_nxt;
      stop_r <= stop_nxt;
    end
    last_r <= last_nxt;
    lvl_r <= lvl_nxt;
    nleft_r <= nleft_nxt;
    off_r <= off_nxt;
    pol_r <= pol_nxt;
    p_r <= p_nxt;
    k_r <= k_nxt;
    cbuf_r <= cbuf_nxt;
    bit_r <= bit_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

endmodule

[rtl/rc6d_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rc6d_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/rc6d_div.sv]
// Restoring divider, one quotient bit per cycle, for the cell count of a sample.
// Depends on nothing.
module rc6d_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [24:0] dividend,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [24:0] quotient
);

  logic [24:0] q_r, q_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [11:0] dv_r, dv_nxt;
  logic [13:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    dv_nxt = dv_r;
    done = 1'b0;
    trial = '0;
    if (go) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 5'd0;
      run_nxt = 1'b1;
      dv_nxt = divisor;
    end else if (run_r) begin
      trial = {rem_r, q_r[24]} - {2'b00, dv_r};
      if (!trial[13]) begin
        rem_nxt = trial[12:0];
        q_nxt = {q_r[23:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[11:0], q_r[24]};
        q_nxt = {q_r[23:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd24) begin
        run_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign quotient = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    dv_r <= dv_nxt;
  end

endmodule

[rtl/rc6d_checker.sv]
// Port-level checks for the RC6 decoder, bound to the top level.
// Depends on rc6d_pkg.
module rc6d_checker
  import rc6d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input rc6d_out_t out_data
);

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_busy_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after a request");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data == '0))
    else $error("not-found result carries data");

endmodule

bind rc6_ir_frame_decoder rc6d_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
